// ===== src/iesb_pkg.sv =====
package iesb_pkg;

  localparam int SAMPLE_W = 16;
  localparam int INDEX_W  = 32;
  localparam int WEIGHT_W = 16;
  localparam int WH_W     = 4;
  localparam int OCC_W    = 9;
  localparam int DROP_W   = 32;
  localparam int DIFF_W   = 16;
  localparam int SQ_W     = 32;
  localparam int SUM_W    = 37;
  localparam int DIVR_W   = 5;
  localparam int DIVX_W   = 40;
  localparam int SCORE_W  = 50;
  localparam int PROD_W   = 48;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 96;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_ENERGY = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HALF   = 2'd3;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [WEIGHT_W-1:0] WF_RESET = 16'd6554;
  localparam logic [WEIGHT_W-1:0] WS_RESET = 16'd19661;
  localparam logic [WEIGHT_W-1:0] WE_RESET = 16'd39322;
  localparam logic [WH_W-1:0]     WH_RESET = 4'd3;

  typedef enum logic [19:0] {
    S_IDLE = 20'h00001,
    S_DISP = 20'h00002,
    S_POPW = 20'h00004,
    S_LDRD = 20'h00008,
    S_LDWR = 20'h00010,
    S_SCA  = 20'h00020,
    S_SCAW = 20'h00040,
    S_ADD  = 20'h00080,
    S_ADDW = 20'h00100,
    S_ADDA = 20'h00200,
    S_SUB  = 20'h00400,
    S_SUBW = 20'h00800,
    S_SUBA = 20'h01000,
    S_DIV  = 20'h02000,
    S_MUL  = 20'h04000,
    S_CMP  = 20'h08000,
    S_SHRD = 20'h10000,
    S_SHWR = 20'h20000,
    S_PUSH = 20'h40000,
    S_DONE = 20'h80000
  } state_t;

endpackage

// ===== src/iesb_ram.sv =====
module iesb_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/importance_eviction_sample_buffer_core.sv =====
// Bounded sample FIFO with importance eviction. A pop reads the oldest
// entry and a push into a non-full buffer writes at the tail; the output
// register then hands the result over. A push into a full buffer first
// reads every stored sample and writes the absolute difference of each
// neighbouring pair into a difference memory, then scores each interior
// position through reads of that memory, a window-mean divider and a
// multiplier shared by the three weighted terms, then closes the gap over
// the evicted entry. The input is taken only between items; a finished
// result waits in the output register while the next item is accepted.
module importance_eviction_sample_buffer_core
  import iesb_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // sample, sample_index
  input  logic                  in_tuser,   // op
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // out_sample, out_index, was_empty,
                                            // evicted, occupancy, drop_total, pad
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [WEIGHT_W-1:0]   cfg_wdata
);

  localparam int PW  = $clog2(CAPACITY);
  localparam int PW1 = PW + 1;
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int XW  = PW + 5;
  localparam int MW  = SAMPLE_W + INDEX_W;
  localparam logic [PW:0]   CAP_P  = PW1'(CAPACITY);
  localparam logic [PW-1:0] LAST_I = PW'(CAPACITY - 2);
  localparam logic [PW-1:0] LAST_P = PW'(CAPACITY - 1);
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
  localparam logic [XW-1:0] CAP_X  = XW'(CAPACITY);

  function automatic logic [PW-1:0] slot(input logic [PW-1:0] base,
                                         input logic [PW-1:0] pos);
    logic [PW:0] s;
    s = {1'b0, base} + {1'b0, pos};
    if (s >= CAP_P) s = s - CAP_P;
    return s[PW-1:0];
  endfunction

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
    logic [PW:0] s;
    s = {1'b0, p} + 1'b1;
    if (s >= CAP_P) s = '0;
    return s[PW-1:0];
  endfunction

  state_t state_r, state_nxt;

  logic [PW-1:0]       rp_r, wp_r, pos_r, best_r;
  logic [CW-1:0]       fill_r;
  logic [DROP_W-1:0]   drop_r;
  logic [WEIGHT_W-1:0] wf_r, ws_r, we_r;
  logic [WH_W-1:0]     wh_r;
  logic                op_r;
  logic [SAMPLE_W-1:0] smp_r, prevx_r;
  logic [INDEX_W-1:0]  sidx_r;
  logic [DIFF_W-1:0]   prev_a_r, d1_r, d2_r;
  logic [XW-1:0]       lo_r, hi_r;
  logic [SUM_W-1:0]    sum_r;
  logic [SQ_W-1:0]     sq_r;
  logic [DIVX_W-1:0]   dv_r;
  logic [SQ_W-1:0]     q_r;
  logic [DIVR_W-1:0]   rem_r, div_d_r;
  logic [2:0]          dcnt_r;
  logic [1:0]          mcnt_r;
  logic [PROD_W-1:0]   prod_r;
  logic [SCORE_W-1:0]  acc_r, best_score_r;
  logic [SAMPLE_W-1:0] res_sample_r;
  logic [INDEX_W-1:0]  res_index_r;
  logic                res_empty_r, res_ev_r;
  logic                out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  logic          m_we;
  logic [PW-1:0] m_waddr, m_raddr;
  logic [MW-1:0] m_wdata, m_rdata;
  logic          a_we;
  logic [PW-1:0] a_waddr, a_raddr;
  logic [DIFF_W-1:0] a_wdata, a_rdata;

  iesb_ram #(.WIDTH(MW), .DEPTH(CAPACITY)) u_main (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  iesb_ram #(.WIDTH(DIFF_W), .DEPTH(CAPACITY)) u_diff (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .raddr(a_raddr), .rdata(a_rdata)
  );

  logic                  in_acc, out_load;
  logic [XW-1:0]         ix, hi_t, lo_t, cntx;
  logic signed [SAMPLE_W:0] dx;
  logic [DIFF_W-1:0]     ax, a_dd;
  logic [DIVR_W-1:0]     dr;
  logic [7:0]            qb;
  logic [WEIGHT_W-1:0]   mop_a;
  logic [SQ_W-1:0]       mop_b;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_load   = (state_r == S_DONE) && (!out_tvalid_r || out_tready);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_comb begin
    ix   = XW'(pos_r);
    hi_t = (ix + XW'(wh_r) < CAP_X) ? ix + XW'(wh_r) : CAP_X - 1'b1;
    lo_t = (ix > XW'(wh_r)) ? ix - XW'(wh_r) + 1'b1 : XW'(1);
    cntx = hi_r + 1'b1 - lo_r;
    dx   = $signed({m_rdata[SAMPLE_W-1], m_rdata[SAMPLE_W-1:0]})
         - $signed({prevx_r[SAMPLE_W-1], prevx_r});
    ax   = dx[SAMPLE_W] ? DIFF_W'(-dx) : DIFF_W'(dx);
    a_dd = (a_rdata >= prev_a_r) ? a_rdata - prev_a_r : prev_a_r - a_rdata;
  end

  // eight quotient bits per cycle, remainder stays below the divisor
  always_comb begin
    logic [DIVR_W:0] t;
    dr = rem_r;
    qb = '0;
    for (int k = 7; k >= 0; k--) begin
      t = {dr, dv_r[DIVX_W-8+k]};
      if (t >= {1'b0, div_d_r}) begin
        dr = DIVR_W'(t - {1'b0, div_d_r});
        qb[k] = 1'b1;
      end else begin
        dr = t[DIVR_W-1:0];
      end
    end
  end

  always_comb begin
    case (mcnt_r)
      2'd0: begin
        mop_a = wf_r;
        mop_b = SQ_W'(d1_r);
      end
      2'd1: begin
        mop_a = ws_r;
        mop_b = SQ_W'(d2_r);
      end
      default: begin
        mop_a = we_r;
        mop_b = q_r;
      end
    endcase
  end

  always_comb begin
    m_we    = 1'b0;
    m_waddr = wp_r;
    m_wdata = {sidx_r, smp_r};
    m_raddr = slot(rp_r, pos_r);
    a_we    = 1'b0;
    a_waddr = pos_r;
    a_wdata = ax;
    a_raddr = pos_r;
    case (state_r)
      S_DISP: m_raddr = rp_r;
      S_LDWR: a_we = (pos_r != '0);
      S_ADD:  a_raddr = PW'(hi_r + 1'b1);
      S_SUB:  a_raddr = lo_r[PW-1:0];
      S_SHRD: m_raddr = slot(rp_r, inc(pos_r));
      S_SHWR: begin
        m_we    = 1'b1;
        m_waddr = slot(rp_r, pos_r);
        m_wdata = m_rdata;
      end
      S_PUSH: m_we = 1'b1;
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_DISP;
      S_DISP: begin
        if (op_r == OP_POP) begin
          state_nxt = (fill_r == '0) ? S_DONE : S_POPW;
        end else begin
          state_nxt = (fill_r == CAP_C) ? S_LDRD : S_PUSH;
        end
      end
      S_POPW: state_nxt = S_DONE;
      S_LDRD: state_nxt = S_LDWR;
      S_LDWR: state_nxt = (pos_r == LAST_P) ? S_SCA : S_LDRD;
      S_SCA:  state_nxt = S_SCAW;
      S_SCAW: state_nxt = S_ADD;
      S_ADD:  state_nxt = (hi_r < hi_t) ? S_ADDW : S_SUB;
      S_ADDW: state_nxt = S_ADDA;
      S_ADDA: state_nxt = S_ADD;
      S_SUB: begin
        if (lo_r < lo_t) state_nxt = S_SUBW;
        else state_nxt = (cntx == '0) ? S_MUL : S_DIV;
      end
      S_SUBW: state_nxt = S_SUBA;
      S_SUBA: state_nxt = S_SUB;
      S_DIV:  if (dcnt_r == 3'd4) state_nxt = S_MUL;
      S_MUL:  if (mcnt_r == 2'd3) state_nxt = S_CMP;
      S_CMP:  state_nxt = (pos_r == LAST_I) ? S_SHRD : S_SCA;
      S_SHRD: state_nxt = S_SHWR;
      S_SHWR: state_nxt = (pos_r == LAST_I) ? S_PUSH : S_SHRD;
      S_PUSH: state_nxt = S_DONE;
      S_DONE: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rp_r         <= '0;
      wp_r         <= '0;
      fill_r       <= '0;
      drop_r       <= '0;
      wf_r         <= WF_RESET;
      ws_r         <= WS_RESET;
      we_r         <= WE_RESET;
      wh_r         <= WH_RESET;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_WEIGHT_FIRST:  wf_r <= cfg_wdata;
          REG_WEIGHT_SECOND: ws_r <= cfg_wdata;
          REG_WEIGHT_ENERGY: we_r <= cfg_wdata;
          REG_WINDOW_HALF:   wh_r <= cfg_wdata[WH_W-1:0];
          default: begin
          end
        endcase
      end
      if (out_load) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
      case (state_r)
        S_POPW: begin
          rp_r   <= inc(rp_r);
          fill_r <= fill_r - 1'b1;
        end
        S_SHWR: begin
          if (pos_r == LAST_I) begin
            wp_r   <= slot(rp_r, LAST_P);
            fill_r <= fill_r - 1'b1;
            if (drop_r != '1) drop_r <= drop_r + 1'b1;
          end
        end
        S_PUSH: begin
          wp_r   <= inc(wp_r);
          fill_r <= fill_r + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_tuser;
      smp_r  <= in_tdata[SAMPLE_W-1:0];
      sidx_r <= in_tdata[SAMPLE_W +: INDEX_W];
    end
    if (out_load) begin
      out_tdata_r <= {5'b0, drop_r, OCC_W'(fill_r), res_ev_r, res_empty_r,
                      res_index_r, res_sample_r};
    end
    case (state_r)
      S_DISP: begin
        res_sample_r <= '0;
        res_index_r  <= '0;
        res_ev_r     <= 1'b0;
        res_empty_r  <= (op_r == OP_POP) && (fill_r == '0);
        pos_r        <= '0;
      end
      S_POPW: begin
        res_sample_r <= m_rdata[SAMPLE_W-1:0];
        res_index_r  <= m_rdata[SAMPLE_W +: INDEX_W];
      end
      S_LDWR: begin
        prevx_r <= m_rdata[SAMPLE_W-1:0];
        if (pos_r == LAST_P) begin
          pos_r <= PW'(1);
          lo_r  <= XW'(1);
          hi_r  <= '0;
          sum_r <= '0;
        end else begin
          pos_r <= pos_r + 1'b1;
        end
      end
      S_SCAW: begin
        d1_r     <= a_rdata;
        d2_r     <= (pos_r >= PW'(2)) ? a_dd : '0;
        prev_a_r <= a_rdata;
      end
      S_ADDW, S_SUBW: sq_r <= a_rdata * a_rdata;
      S_ADDA: begin
        sum_r <= sum_r + SUM_W'(sq_r);
        hi_r  <= hi_r + 1'b1;
      end
      S_SUBA: begin
        sum_r <= sum_r - SUM_W'(sq_r);
        lo_r  <= lo_r + 1'b1;
      end
      S_SUB: begin
        dv_r    <= DIVX_W'(sum_r);
        rem_r   <= '0;
        dcnt_r  <= '0;
        div_d_r <= cntx[DIVR_W-1:0];
        q_r     <= '0;
        mcnt_r  <= '0;
      end
      S_DIV: begin
        dv_r   <= dv_r << 8;
        q_r    <= {q_r[SQ_W-9:0], qb};
        rem_r  <= dr;
        dcnt_r <= dcnt_r + 1'b1;
      end
      S_MUL: begin
        prod_r <= {32'b0, mop_a} * {16'b0, mop_b};
        acc_r  <= (mcnt_r == 2'd0) ? '0 : acc_r + SCORE_W'(prod_r);
        mcnt_r <= mcnt_r + 1'b1;
      end
      S_CMP: begin
        if (pos_r == PW'(1) || acc_r < best_score_r) begin
          best_score_r <= acc_r;
          best_r       <= pos_r;
        end
        if (pos_r == LAST_I) begin
          pos_r <= (pos_r == PW'(1) || acc_r < best_score_r) ? pos_r : best_r;
        end else begin
          pos_r <= pos_r + 1'b1;
        end
      end
      S_SHWR: begin
        if (pos_r == LAST_I) res_ev_r <= 1'b1;
        else pos_r <= pos_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CAP_C)
    else $error("fill count above capacity");

  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUSH && res_ev_r) |=> fill_r == CAP_C)
    else $error("evicting push did not leave the buffer full");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DISP && op_r == OP_POP && fill_r == '0) |=>
      $stable(rp_r) && $stable(fill_r))
    else $error("empty pop changed the buffer");

  a_drop_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> drop_r >= $past(drop_r))
    else $error("drop counter went down");

endmodule
